// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the interpolator RTL.
// Each macro expands to one labelled concurrent assertion, reset-gated.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define TVFI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define TVFI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/tvfi_pkg.sv -----
// Package of the trilinear field interpolator: grid constants, register
// indexes, the configuration struct and the sequencer states. No dependencies.
`timescale 1ns / 1ps

package tvfi_pkg;

	localparam int GRID_NX     = 32;
	localparam int GRID_NY     = 32;
	localparam int GRID_NZ     = 32;
	localparam int TABLE_DEPTH = 32768;
	localparam int ADDR_W      = 15;
	localparam int IDX_W       = 8;
	localparam int STRIDE_X    = GRID_NY * GRID_NZ;
	localparam int STRIDE_Y    = GRID_NZ;
	localparam int PADDR_W     = 5;
	localparam int ACC_W       = 56;

	localparam logic [23:0] TOP_X = 24'((GRID_NX - 1) * 65536);
	localparam logic [23:0] TOP_Y = 24'((GRID_NY - 1) * 65536);
	localparam logic [23:0] TOP_Z = 24'((GRID_NZ - 1) * 65536);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		REG_MIN_X       = 3'd0,
		REG_MIN_Y       = 3'd1,
		REG_MIN_Z       = 3'd2,
		REG_SCALE_X     = 3'd3,
		REG_SCALE_Y     = 3'd4,
		REG_SCALE_Z     = 3'd5,
		REG_INVERT_MASK = 3'd6,
		REG_Z_OFFSET    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] min_z;
		logic [31:0]        scale_x;
		logic [31:0]        scale_y;
		logic [31:0]        scale_z;
		logic [2:0]         invert_mask;
		logic signed [31:0] z_offset;
	} tvfi_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_COORD,
		ST_BASE,
		ST_WXY,
		ST_WZ,
		ST_MX,
		ST_MY,
		ST_MZ,
		ST_FIN,
		ST_DONE
	} tvfi_state_t;

endpackage

// ----- hdl/tvfi_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tvfi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/tvfi_regs.sv -----
// APB configuration registers of the interpolator.
// Depends on tvfi_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module tvfi_regs import tvfi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output tvfi_cfg_t          cfg
);

	tvfi_cfg_t cfg_q;
	reg_idx_t  idx;
	logic      wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_X:       cfg_q.min_x       <= pwdata;
				REG_MIN_Y:       cfg_q.min_y       <= pwdata;
				REG_MIN_Z:       cfg_q.min_z       <= pwdata;
				REG_SCALE_X:     cfg_q.scale_x     <= pwdata;
				REG_SCALE_Y:     cfg_q.scale_y     <= pwdata;
				REG_SCALE_Z:     cfg_q.scale_z     <= pwdata;
				REG_INVERT_MASK: cfg_q.invert_mask <= pwdata[2:0];
				REG_Z_OFFSET:    cfg_q.z_offset    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_X:       prdata = cfg_q.min_x;
			REG_MIN_Y:       prdata = cfg_q.min_y;
			REG_MIN_Z:       prdata = cfg_q.min_z;
			REG_SCALE_X:     prdata = cfg_q.scale_x;
			REG_SCALE_Y:     prdata = cfg_q.scale_y;
			REG_SCALE_Z:     prdata = cfg_q.scale_z;
			REG_INVERT_MASK: prdata = {29'd0, cfg_q.invert_mask};
			REG_Z_OFFSET:    prdata = cfg_q.z_offset;
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- hdl/trilinear_vector_field_interpolator_unit.sv -----
// A load writes the three field tables and gives no result; a query gives its result
// after its grid mappings and corner products (sooner when it falls outside the grid).
// New input stalls until a query's result is handed off; the single 33x33 multiplier
// serves three grid mappings, sixteen weight products and 24 corner products.
// Reset clears the configuration, sequencer and output valid; datapath registers and field tables hold no reset value.
// Depends on tvfi_pkg, tvfi_regs, tvfi_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trilinear_vector_field_interpolator_unit import tvfi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [14:0]        grid_index,
	input  logic signed [31:0] load_bx,
	input  logic signed [31:0] load_by,
	input  logic signed [31:0] load_bz,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] field_x,
	output logic signed [31:0] field_y,
	output logic signed [31:0] field_z,
	output logic               in_region
);

	tvfi_cfg_t   cfg;
	tvfi_state_t state_q, state_d;

	logic               in_acc, load_we, query_acc;
	logic [1:0]         k_q;
	logic [2:0]         corner_q;
	logic signed [31:0] px_q, py_q;
	logic signed [32:0] pz_q;
	logic signed [33:0] d_q, d_d, pos_sel, min_sel;
	logic [31:0]        scale_sel;
	logic [23:0]        top_sel;
	logic               inv_sel, d_out;
	logic signed [65:0] prod_q, product;
	logic signed [32:0] mul_a, mul_b;
	logic [48:0]        g_sum, g_top;
	logic [23:0]        g_fin;
	logic               g_out;
	logic [IDX_W-1:0]   ix_q, iy_q, iz_q;
	logic [15:0]        fx_q, fy_q, fz_q;
	logic [16:0]        wx_sel, wy_sel, wz_sel, w_q;
	logic [ADDR_W-1:0]  base_q, rd_addr;
	logic [31:0]        base_sum, off_sum;
	logic signed [31:0] rd_bx, rd_by, rd_bz;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic               zpend_q, region_q, emit;
	logic               out_valid_q, in_region_q;
	logic signed [31:0] field_x_q, field_y_q, field_z_q;

	tvfi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign load_we   = in_acc && (cmd == CMD_LOAD);
	assign query_acc = in_acc && (cmd == CMD_QUERY);

	assign off_sum = 32'(corner_q[2]) * 32'(STRIDE_X) + 32'(corner_q[1]) * 32'(STRIDE_Y)
		+ 32'(corner_q[0]);
	assign rd_addr = base_q + off_sum[ADDR_W-1:0];

	tvfi_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_bx (
		.clk (clk), .we (load_we), .waddr (grid_index), .wdata (load_bx),
		.raddr (rd_addr), .rdata (rd_bx)
	);
	tvfi_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_by (
		.clk (clk), .we (load_we), .waddr (grid_index), .wdata (load_by),
		.raddr (rd_addr), .rdata (rd_by)
	);
	tvfi_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_bz (
		.clk (clk), .we (load_we), .waddr (grid_index), .wdata (load_bz),
		.raddr (rd_addr), .rdata (rd_bz)
	);

	// per-axis selection for the grid mapping
	always_comb begin
		case (k_q)
			2'd0: begin
				pos_sel   = 34'(px_q);
				min_sel   = 34'(cfg.min_x);
				scale_sel = cfg.scale_x;
				top_sel   = TOP_X;
				inv_sel   = cfg.invert_mask[0];
			end
			2'd1: begin
				pos_sel   = 34'(py_q);
				min_sel   = 34'(cfg.min_y);
				scale_sel = cfg.scale_y;
				top_sel   = TOP_Y;
				inv_sel   = cfg.invert_mask[1];
			end
			default: begin
				pos_sel   = 34'(pz_q);
				min_sel   = 34'(cfg.min_z);
				scale_sel = cfg.scale_z;
				top_sel   = TOP_Z;
				inv_sel   = cfg.invert_mask[2];
			end
		endcase
	end

	assign d_d   = pos_sel - min_sel;
	assign d_out = d_d[33] || (d_d == '0);
	// high part of the offset contributes scale << 16, the low part the product
	assign g_sum = (d_q[32] ? {1'b0, scale_sel, 16'd0} : 49'd0) + {1'b0, prod_q[63:16]};
	assign g_top = {25'd0, top_sel};
	assign g_out = (g_sum == '0) || (g_sum >= g_top);
	assign g_fin = inv_sel ? (top_sel - g_sum[23:0]) : g_sum[23:0];

	assign wx_sel = corner_q[2] ? {1'b0, fx_q} : (17'h10000 - {1'b0, fx_q});
	assign wy_sel = corner_q[1] ? {1'b0, fy_q} : (17'h10000 - {1'b0, fy_q});
	assign wz_sel = corner_q[0] ? {1'b0, fz_q} : (17'h10000 - {1'b0, fz_q});

	assign base_sum = 32'(ix_q) * 32'(STRIDE_X) + 32'(iy_q) * 32'(STRIDE_Y) + 32'(iz_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (query_acc) state_d = ST_DIFF;
			ST_DIFF:  state_d = d_out ? ST_DONE : ST_MUL;
			ST_MUL:   state_d = ST_COORD;
			ST_COORD: begin
				if (g_out) begin
					state_d = ST_DONE;
				end else if (k_q == 2'd2) begin
					state_d = ST_BASE;
				end else begin
					state_d = ST_DIFF;
				end
			end
			ST_BASE:  state_d = ST_WXY;
			ST_WXY:   state_d = ST_WZ;
			ST_WZ:    state_d = ST_MX;
			ST_MX:    state_d = ST_MY;
			ST_MY:    state_d = ST_MZ;
			ST_MZ:    state_d = (corner_q == 3'd7) ? ST_FIN : ST_WXY;
			ST_FIN:   state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// multiplier operands and result hand-off
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		emit  = 1'b0;
		case (state_q)
			ST_MUL: begin
				mul_a = {1'b0, d_q[31:0]};
				mul_b = {1'b0, scale_sel};
			end
			ST_WXY: begin
				mul_a = {16'd0, wx_sel};
				mul_b = {16'd0, wy_sel};
			end
			ST_WZ: begin
				mul_a = {16'd0, prod_q[32:16]};
				mul_b = {16'd0, wz_sel};
			end
			ST_MX: begin
				mul_a = 33'(rd_bx);
				mul_b = {16'd0, prod_q[32:16]};
			end
			ST_MY: begin
				mul_a = 33'(rd_by);
				mul_b = {16'd0, w_q};
			end
			ST_MZ: begin
				mul_a = 33'(rd_bz);
				mul_b = {16'd0, w_q};
			end
			ST_DONE: emit = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	assign product = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			corner_q    <= '0;
			zpend_q     <= 1'b0;
			region_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (query_acc) begin
				k_q      <= '0;
				corner_q <= '0;
				zpend_q  <= 1'b0;
				region_q <= 1'b1;
			end
			case (state_q)
				ST_DIFF:  if (d_out) region_q <= 1'b0;
				ST_COORD: begin
					if (g_out) begin
						region_q <= 1'b0;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_WXY, ST_FIN: zpend_q <= 1'b0;
				ST_MZ: begin
					zpend_q  <= 1'b1;
					corner_q <= corner_q + 3'd1;
				end
				default: ;
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (query_acc) begin
			px_q    <= pos_x;
			py_q    <= pos_y;
			pz_q    <= 33'(pos_z) + 33'(cfg.z_offset);
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end
		case (state_q)
			ST_DIFF:  d_q <= d_d;
			ST_COORD: begin
				case (k_q)
					2'd0: begin
						ix_q <= g_fin[23:16];
						fx_q <= g_fin[15:0];
					end
					2'd1: begin
						iy_q <= g_fin[23:16];
						fy_q <= g_fin[15:0];
					end
					default: begin
						iz_q <= g_fin[23:16];
						fz_q <= g_fin[15:0];
					end
				endcase
			end
			ST_BASE:  base_q <= base_sum[ADDR_W-1:0];
			ST_MX:    w_q <= prod_q[32:16];
			ST_MY:    acc_x_q <= acc_x_q + prod_q[ACC_W-1:0];
			ST_MZ:    acc_y_q <= acc_y_q + prod_q[ACC_W-1:0];
			ST_WXY, ST_FIN: if (zpend_q) acc_z_q <= acc_z_q + prod_q[ACC_W-1:0];
			default: ;
		endcase
		if (state_q == ST_MUL || state_q == ST_WXY || state_q == ST_WZ
			|| state_q == ST_MX || state_q == ST_MY || state_q == ST_MZ) begin
			prod_q <= product;
		end
		// drop the low sixteen bits: arithmetic shift floors the sum
		if (emit) begin
			field_x_q   <= region_q ? acc_x_q[47:16] : 32'sd0;
			field_y_q   <= region_q ? acc_y_q[47:16] : 32'sd0;
			field_z_q   <= region_q ? acc_z_q[47:16] : 32'sd0;
			in_region_q <= region_q;
		end
	end

	assign out_valid = out_valid_q;
	assign field_x   = field_x_q;
	assign field_y   = field_y_q;
	assign field_z   = field_z_q;
	assign in_region = in_region_q;

	`TVFI_ASSERT_IMP(a_zero_outside, clk, arst_n, out_valid && !in_region,
		field_x == 0 && field_y == 0 && field_z == 0)
	`TVFI_ASSERT_NXT(a_query_starts, clk, arst_n, query_acc, state_q == ST_DIFF)
	`TVFI_ASSERT_IMP(a_result_from_done, clk, arst_n, $rose(out_valid),
		$past(state_q) == ST_DONE)

endmodule
